[design/soa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// soa_pkg
// Shared widths, codes and beat types for the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int OBJS_MAX  = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS + 1);
    localparam int SIDX_W    = $clog2(NUM_SLOTS);
    localparam int OBJ_W     = $clog2(OBJS_MAX);
    localparam int LINK_W    = $clog2(OBJS_MAX + 2);
    localparam int CNT_W     = $clog2(OBJS_MAX + 1);
    localparam int LADDR_W   = SIDX_W + OBJ_W;

    localparam logic [SLOT_W-1:0] SLOT_NIL  = SLOT_W'(NUM_SLOTS);
    localparam logic [LINK_W-1:0] LINK_NIL  = LINK_W'(OBJS_MAX);
    localparam logic [LINK_W-1:0] LINK_USED = LINK_W'(OBJS_MAX + 1);

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;

    localparam logic [1:0] KIND_GRANT = 2'd0;
    localparam logic [1:0] KIND_FAIL  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_REL   = 2'd3;

    localparam logic [1:0] CFG_OBJS    = 2'd0;
    localparam logic [1:0] CFG_MAXFREE = 2'd1;
    localparam logic [1:0] CFG_RELEN   = 2'd2;

    // slot list selectors
    localparam logic [1:0] LIST_FULL  = 2'd0;
    localparam logic [1:0] LIST_PART  = 2'd1;
    localparam logic [1:0] LIST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slab_index;
        logic [5:0]  object_index;
        logic [31:0] slab_tag;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_slab;
        logic [5:0]  out_object;
        logic [31:0] out_tag;
        logic        last;
    } out_beat_t;

    // object link memory port
    typedef struct packed {
        logic               we;
        logic [LADDR_W-1:0] addr;
        logic [LINK_W-1:0]  wdata;
    } link_req_t;

endpackage
`default_nettype wire

[design/soa_link_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// soa_link_ram
// Object link store: one read/write port, registered read data.
// ----------------------------------------------------------------------------
module soa_link_ram (
    input  wire logic                               aclk,
    input  wire soa_pkg::link_req_t                 req,
    output logic [soa_pkg::LINK_W-1:0]              rdata
);
    logic [soa_pkg::LINK_W-1:0] mem [0:(1 << soa_pkg::LADDR_W)-1];

    // read first port; read data is registered and lands in the cycle after the address
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end
endmodule
`default_nettype wire

[design/slab_object_allocator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slab_object_allocator_unit
// Slab allocator over a fixed pool of slots with per-slot free lists.
// ----------------------------------------------------------------------------
// Usage: input beats (s_valid/s_ready, in_beat_t) carry allocate, free or
// add-slab requests. Result beats (m_valid/m_ready, out_beat_t) leave in
// order; the final beat of a request carries last. Config writes
// (cfg_valid/cfg_ready, index and data) are taken at any time and are meant
// while the block is idle.
// Timing: one request at a time. Allocate and free each make a single
// read-modify-write pass on the object link memory. A free that releases
// slots then gives one beat a cycle while the receiver does not stall.
// Add-slab writes one link entry a cycle.
// Slot descriptors live in small registers; object links in one memory.
// Reset clears list heads, counters and live bits at once; the link memory
// needs no clearing pass. A stalled receiver holds the result register and
// the sequencer waits; s_ready stays low until the request is finished.
// ----------------------------------------------------------------------------
module slab_object_allocator_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire soa_pkg::in_beat_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output soa_pkg::out_beat_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    localparam int SW = soa_pkg::SLOT_W;
    localparam int IW = soa_pkg::SIDX_W;
    localparam int OW = soa_pkg::OBJ_W;
    localparam int LW = soa_pkg::LINK_W;
    localparam int CW = soa_pkg::CNT_W;
    localparam int NUM_S = soa_pkg::NUM_SLOTS;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_WAIT  = 7'b0000100,
        ST_UPD   = 7'b0001000,
        ST_FILL  = 7'b0010000,
        ST_REL   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0] objs_reg;
    logic [4:0] maxf_reg;
    logic       relen_reg;

    logic [LW-1:0]   fhead_reg [NUM_S];
    logic [CW-1:0]   fcnt_reg  [NUM_S];
    logic [SW-1:0]   prev_reg  [NUM_S];
    logic [SW-1:0]   next_reg  [NUM_S];
    logic [31:0]     tag_reg   [NUM_S];
    logic [NUM_S-1:0] live_reg;

    logic [SW-1:0] hfull_reg, hpart_reg, hempty_reg;
    logic [SW-1:0] total_reg, etotal_reg;

    soa_pkg::in_beat_t req_reg;
    logic [IW-1:0]     slot_reg;
    logic [OW-1:0]     obj_reg;
    logic [OW-1:0]     fill_reg;
    logic [4:0]        nrel_reg;

    soa_pkg::link_req_t lreq;
    logic [LW-1:0]      lrdata;

    soa_pkg::out_beat_t out_reg;
    logic               outv_reg;

    soa_link_ram u_link (.aclk(aclk), .req(lreq), .rdata(lrdata));

    // effective objects per slab
    logic [CW-1:0] n_eff;
    always_comb begin
        if (objs_reg < 7'd2) begin
            n_eff = CW'(2);
        end else if (objs_reg > 7'(soa_pkg::OBJS_MAX)) begin
            n_eff = CW'(soa_pkg::OBJS_MAX);
        end else begin
            n_eff = CW'(objs_reg);
        end
    end

    // alloc source slot
    logic [SW-1:0] src;
    assign src = (hpart_reg != soa_pkg::SLOT_NIL) ? hpart_reg : hempty_reg;

    assign s_ready   = (state_reg == ST_IDLE) && !outv_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = outv_reg;
    assign m_data    = out_reg;

    // link memory port; address held through the wait so read data stays put
    always_comb begin
        lreq = '0;
        case (state_reg)
            ST_RD, ST_WAIT: begin
                lreq.addr = {slot_reg, obj_reg};
            end
            ST_UPD: begin
                lreq.we   = 1'b1;
                lreq.addr = {slot_reg, obj_reg};
                lreq.wdata = (req_reg.mode == soa_pkg::MODE_ALLOC)
                             ? soa_pkg::LINK_USED : fhead_reg[slot_reg];
            end
            ST_FILL: begin
                lreq.we   = 1'b1;
                lreq.addr = {slot_reg, fill_reg};
                lreq.wdata = ((CW'(fill_reg) + CW'(1)) == n_eff)
                             ? soa_pkg::LINK_NIL : LW'(fill_reg) + LW'(1);
            end
            default: begin
                lreq = '0;
            end
        endcase
    end

    function automatic soa_pkg::out_beat_t mk(logic [1:0] k, logic [3:0] s,
                                               logic [5:0] o, logic [31:0] t,
                                               logic l);
        soa_pkg::out_beat_t b;
        b.kind = k; b.out_slab = s; b.out_object = o; b.out_tag = t; b.last = l;
        return b;
    endfunction

    logic           free_ok;
    assign free_ok = live_reg[slot_reg] && (CW'(obj_reg) < n_eff);

    // sequencer and slot descriptor updates
    always_ff @(posedge aclk) begin
        logic [SW-1:0] p, nx, s;
        logic [SW-1:0] hf, hp, he;
        logic [SW-1:0] et;
        logic          mv;
        logic [1:0]    fl, tl;
        logic [CW-1:0] cnt_new;
        logic          ov;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            objs_reg      <= 7'd8;
            maxf_reg      <= 5'd1;
            relen_reg     <= 1'b1;
            live_reg      <= '0;
            hfull_reg     <= soa_pkg::SLOT_NIL;
            hpart_reg     <= soa_pkg::SLOT_NIL;
            hempty_reg    <= soa_pkg::SLOT_NIL;
            total_reg     <= '0;
            etotal_reg    <= '0;
            outv_reg      <= 1'b0;
        end else begin
            ov = outv_reg && !m_ready;
            // configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    soa_pkg::CFG_OBJS:
                        if (total_reg == '0) objs_reg <= cfg_data[6:0];
                    soa_pkg::CFG_MAXFREE: maxf_reg <= cfg_data[4:0];
                    soa_pkg::CFG_RELEN:   relen_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            hf = hfull_reg; hp = hpart_reg; he = hempty_reg; et = etotal_reg;
            mv = 1'b0; fl = soa_pkg::LIST_FULL; tl = soa_pkg::LIST_FULL;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg  <= s_data;
                        slot_reg <= s_data.slab_index;
                        obj_reg  <= s_data.object_index;
                        fill_reg <= '0;
                        nrel_reg <= '0;
                        case (s_data.mode)
                            soa_pkg::MODE_ALLOC: begin
                                if (src == soa_pkg::SLOT_NIL ||
                                    fhead_reg[src[IW-1:0]] >= LW'(n_eff) ||
                                    fcnt_reg[src[IW-1:0]] == '0) begin
                                    out_reg  <= mk(soa_pkg::KIND_FAIL, '0, '0, '0, 1'b1);
                                    ov = 1'b1;
                                end else begin
                                    slot_reg  <= src[IW-1:0];
                                    obj_reg   <= fhead_reg[src[IW-1:0]][OW-1:0];
                                    state_reg <= ST_RD;
                                end
                            end
                            soa_pkg::MODE_FREE: state_reg <= ST_RD;
                            soa_pkg::MODE_ADD: begin
                                if (!live_reg[s_data.slab_index]) begin
                                    state_reg <= ST_FILL;
                                end else begin
                                    out_reg  <= mk(soa_pkg::KIND_DONE, '0, '0, '0, 1'b1);
                                    ov = 1'b1;
                                end
                            end
                            default: begin
                                out_reg  <= mk(soa_pkg::KIND_DONE, '0, '0, '0, 1'b1);
                                ov = 1'b1;
                            end
                        endcase
                    end
                end
                ST_RD: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (req_reg.mode == soa_pkg::MODE_ALLOC) begin
                        state_reg <= ST_UPD;
                    end else if (free_ok && lrdata == soa_pkg::LINK_USED) begin
                        state_reg <= ST_UPD;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_UPD: begin
                    s = SW'(slot_reg);
                    if (req_reg.mode == soa_pkg::MODE_ALLOC) begin
                        cnt_new = fcnt_reg[slot_reg] - CW'(1);
                        fhead_reg[slot_reg] <= lrdata;
                        fcnt_reg[slot_reg]  <= cnt_new;
                        // fl: list the slot leaves; tl: list it joins
                        fl = (hpart_reg == s) ? soa_pkg::LIST_PART : soa_pkg::LIST_EMPTY;
                        if (cnt_new == n_eff - CW'(1)) begin
                            mv = 1'b1; tl = soa_pkg::LIST_PART;
                            if (et != '0) et = et - SW'(1);
                        end else if (cnt_new == '0) begin
                            mv = 1'b1; tl = soa_pkg::LIST_FULL;
                        end
                        out_reg  <= mk(soa_pkg::KIND_GRANT, slot_reg, obj_reg, '0, 1'b1);
                        ov = 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_new = fcnt_reg[slot_reg] + CW'(1);
                        fhead_reg[slot_reg] <= LW'(obj_reg);
                        fcnt_reg[slot_reg]  <= cnt_new;
                        if (cnt_new == CW'(1)) begin
                            mv = 1'b1; fl = soa_pkg::LIST_FULL; tl = soa_pkg::LIST_PART;
                        end else if (cnt_new == n_eff) begin
                            mv = 1'b1; fl = soa_pkg::LIST_PART; tl = soa_pkg::LIST_EMPTY;
                            et = et + SW'(1);
                        end
                        state_reg <= ST_REL;
                    end
                    if (mv) begin
                        // unlink from source list
                        p = prev_reg[slot_reg]; nx = next_reg[slot_reg];
                        if (p != soa_pkg::SLOT_NIL) next_reg[p[IW-1:0]] <= nx;
                        if (nx != soa_pkg::SLOT_NIL) prev_reg[nx[IW-1:0]] <= p;
                        case (fl)
                            soa_pkg::LIST_PART:  if (hp == s) hp = nx;
                            soa_pkg::LIST_EMPTY: if (he == s) he = nx;
                            default: if (hf == s) hf = nx;
                        endcase
                        // push at head of target list
                        prev_reg[slot_reg] <= soa_pkg::SLOT_NIL;
                        case (tl)
                            soa_pkg::LIST_PART: begin
                                next_reg[slot_reg] <= hp;
                                if (hp != soa_pkg::SLOT_NIL && hp != p)
                                    prev_reg[hp[IW-1:0]] <= s;
                                else if (hp != soa_pkg::SLOT_NIL)
                                    prev_reg[hp[IW-1:0]] <= s;
                                hp = s;
                            end
                            soa_pkg::LIST_EMPTY: begin
                                next_reg[slot_reg] <= he;
                                if (he != soa_pkg::SLOT_NIL) prev_reg[he[IW-1:0]] <= s;
                                he = s;
                            end
                            default: begin
                                next_reg[slot_reg] <= hf;
                                if (hf != soa_pkg::SLOT_NIL) prev_reg[hf[IW-1:0]] <= s;
                                hf = s;
                            end
                        endcase
                    end
                    hfull_reg <= hf; hpart_reg <= hp; hempty_reg <= he;
                    etotal_reg <= et;
                end
                ST_FILL: begin
                    if ((CW'(fill_reg) + CW'(1)) == n_eff) begin
                        s = SW'(slot_reg);
                        fhead_reg[slot_reg] <= '0;
                        fcnt_reg[slot_reg]  <= n_eff;
                        tag_reg[slot_reg]   <= req_reg.slab_tag;
                        live_reg[slot_reg]  <= 1'b1;
                        prev_reg[slot_reg]  <= soa_pkg::SLOT_NIL;
                        next_reg[slot_reg]  <= hempty_reg;
                        if (hempty_reg != soa_pkg::SLOT_NIL)
                            prev_reg[hempty_reg[IW-1:0]] <= s;
                        hempty_reg <= s;
                        total_reg  <= total_reg + SW'(1);
                        etotal_reg <= etotal_reg + SW'(1);
                        state_reg  <= ST_OUT;
                    end else begin
                        fill_reg <= fill_reg + OW'(1);
                    end
                end
                ST_REL: begin
                    if (!outv_reg || m_ready) begin
                        if (relen_reg && etotal_reg > SW'(maxf_reg) &&
                            hempty_reg != soa_pkg::SLOT_NIL &&
                            nrel_reg < 5'(NUM_S)) begin
                            s  = hempty_reg;
                            nx = next_reg[s[IW-1:0]];
                            if (nx != soa_pkg::SLOT_NIL)
                                prev_reg[nx[IW-1:0]] <= soa_pkg::SLOT_NIL;
                            hempty_reg <= nx;
                            prev_reg[s[IW-1:0]] <= soa_pkg::SLOT_NIL;
                            next_reg[s[IW-1:0]] <= soa_pkg::SLOT_NIL;
                            live_reg[s[IW-1:0]] <= 1'b0;
                            if (total_reg != '0) total_reg <= total_reg - SW'(1);
                            etotal_reg <= etotal_reg - SW'(1);
                            nrel_reg   <= nrel_reg + 5'd1;
                            out_reg  <= mk(soa_pkg::KIND_REL, s[IW-1:0], '0,
                                           tag_reg[s[IW-1:0]], 1'b0);
                            ov = 1'b1;
                        end else begin
                            out_reg  <= mk(soa_pkg::KIND_DONE, '0, '0, '0, 1'b1);
                            ov = 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (!outv_reg || m_ready) begin
                        out_reg  <= mk(soa_pkg::KIND_DONE, '0, '0, '0, 1'b1);
                        ov = 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            outv_reg <= ov;
        end
    end

    // result register holds while the receiver stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed under stall");
    // no new request while a request is still in hand
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request accepted while busy");
    // wholly free count never exceeds slot count
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        etotal_reg <= total_reg)
        else $error("free slot count above total");
endmodule
`default_nettype wire

[sim/slab_object_allocator_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator_unit_checker
// Watches the request, result and config channels of the slab allocator,
// keeps its own copy of the slot lists and object free lists, predicts the
// result beats of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module slab_object_allocator_unit_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire soa_pkg::in_beat_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire soa_pkg::out_beat_t m_data,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      fail_count,
    output int                      results_owed
);

    // slot list selectors
    localparam int L_FULL  = 0;
    localparam int L_PART  = 1;
    localparam int L_EMPTY = 2;

    logic [6:0]  objs_reg;
    logic [4:0]  keep_free;
    logic        release_on;

    logic [6:0]  obj_link [soa_pkg::NUM_SLOTS][soa_pkg::OBJS_MAX];
    logic [6:0]  free_top [soa_pkg::NUM_SLOTS];
    logic [6:0]  free_cnt [soa_pkg::NUM_SLOTS];
    logic [4:0]  slot_back [soa_pkg::NUM_SLOTS];
    logic [4:0]  slot_fwd [soa_pkg::NUM_SLOTS];
    logic [31:0] slot_label [soa_pkg::NUM_SLOTS];
    logic        slot_alive [soa_pkg::NUM_SLOTS];
    logic [4:0]  list_head [3];
    int          live_slabs;
    int          idle_slabs;

    soa_pkg::out_beat_t owed_beats [$];

    initial begin
        fail_count   = 0;
        results_owed = 0;
    end

    function automatic logic [6:0] slab_capacity();
        if (objs_reg < 7'd2) return 7'd2;
        if (objs_reg > 7'(soa_pkg::OBJS_MAX)) return 7'(soa_pkg::OBJS_MAX);
        return objs_reg;
    endfunction

    task automatic detach_slot(input int s, input int l);
        logic [4:0] p;
        logic [4:0] nx;
        p  = slot_back[s];
        nx = slot_fwd[s];
        if (p < soa_pkg::NUM_SLOTS) slot_fwd[p] = nx;
        if (nx < soa_pkg::NUM_SLOTS) slot_back[nx] = p;
        if (list_head[l] == 5'(s)) list_head[l] = nx;
        slot_back[s] = soa_pkg::SLOT_NIL;
        slot_fwd[s]  = soa_pkg::SLOT_NIL;
    endtask

    task automatic attach_slot(input int s, input int l);
        slot_back[s] = soa_pkg::SLOT_NIL;
        slot_fwd[s]  = list_head[l];
        if (list_head[l] < soa_pkg::NUM_SLOTS) slot_back[list_head[l]] = 5'(s);
        list_head[l] = 5'(s);
    endtask

    function automatic void owe(logic [1:0] k, int slab, int obj, logic [31:0] tag,
                                logic lst);
        soa_pkg::out_beat_t r;
        r.kind       = k;
        r.out_slab   = 4'(slab);
        r.out_object = 6'(obj);
        r.out_tag    = tag;
        r.last       = lst;
        owed_beats.push_back(r);
    endfunction

    // work out the result beats of one request and update the slot state
    task automatic predict_allocator(input soa_pkg::in_beat_t b);
        logic [6:0] n;
        int         s;
        int         o;
        int         src;
        int         k;
        n = slab_capacity();
        k = 0;
        s = b.slab_index;
        o = b.object_index;
        case (b.mode)
            soa_pkg::MODE_ALLOC: begin
                if (list_head[L_PART] < soa_pkg::NUM_SLOTS) src = L_PART;
                else if (list_head[L_EMPTY] < soa_pkg::NUM_SLOTS) src = L_EMPTY;
                else src = -1;
                if (src < 0) begin
                    owe(soa_pkg::KIND_FAIL, 0, 0, '0, 1'b1);
                end else begin
                    s = list_head[src];
                    o = free_top[s];
                    if (o >= n || free_cnt[s] == 0) begin
                        owe(soa_pkg::KIND_FAIL, 0, 0, '0, 1'b1);
                    end else begin
                        free_top[s]    = obj_link[s][o];
                        obj_link[s][o] = soa_pkg::LINK_USED;
                        free_cnt[s]    = free_cnt[s] - 7'd1;
                        if (free_cnt[s] == n - 7'd1) begin
                            if (idle_slabs > 0) idle_slabs--;
                            detach_slot(s, src);
                            attach_slot(s, L_PART);
                        end else if (free_cnt[s] == 0) begin
                            detach_slot(s, src);
                            attach_slot(s, L_FULL);
                        end
                        owe(soa_pkg::KIND_GRANT, s, o, '0, 1'b1);
                    end
                end
            end
            soa_pkg::MODE_FREE: begin
                if (slot_alive[s] && o < n && obj_link[s][o] == soa_pkg::LINK_USED) begin
                    obj_link[s][o] = free_top[s];
                    free_top[s]    = 7'(o);
                    free_cnt[s]    = free_cnt[s] + 7'd1;
                    if (free_cnt[s] == 7'd1) begin
                        detach_slot(s, L_FULL);
                        attach_slot(s, L_PART);
                    end else if (free_cnt[s] == n) begin
                        idle_slabs++;
                        detach_slot(s, L_PART);
                        attach_slot(s, L_EMPTY);
                    end
                    // hand back surplus wholly free slabs
                    while (release_on && idle_slabs > keep_free &&
                           list_head[L_EMPTY] < soa_pkg::NUM_SLOTS &&
                           k < soa_pkg::NUM_SLOTS) begin
                        s = list_head[L_EMPTY];
                        detach_slot(s, L_EMPTY);
                        slot_alive[s] = 1'b0;
                        if (live_slabs > 0) live_slabs--;
                        idle_slabs--;
                        owe(soa_pkg::KIND_REL, s, 0, slot_label[s], 1'b0);
                        k++;
                    end
                end
                owe(soa_pkg::KIND_DONE, 0, 0, '0, 1'b1);
            end
            soa_pkg::MODE_ADD: begin
                if (!slot_alive[s]) begin
                    for (int i = 0; i + 1 < n; i++) obj_link[s][i] = 7'(i + 1);
                    obj_link[s][n - 7'd1] = soa_pkg::LINK_NIL;
                    free_top[s]   = '0;
                    free_cnt[s]   = n;
                    slot_label[s] = b.slab_tag;
                    slot_alive[s] = 1'b1;
                    attach_slot(s, L_EMPTY);
                    live_slabs++;
                    idle_slabs++;
                end
                owe(soa_pkg::KIND_DONE, 0, 0, '0, 1'b1);
            end
            default: owe(soa_pkg::KIND_DONE, 0, 0, '0, 1'b1);
        endcase
    endtask

    always @(posedge aclk) begin
        soa_pkg::out_beat_t want;
        if (!aresetn) begin
            objs_reg   = 7'd8;
            keep_free  = 5'd1;
            release_on = 1'b1;
            for (int i = 0; i < soa_pkg::NUM_SLOTS; i++) slot_alive[i] = 1'b0;
            for (int i = 0; i < 3; i++) list_head[i] = soa_pkg::SLOT_NIL;
            live_slabs = 0;
            idle_slabs = 0;
            owed_beats.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    soa_pkg::CFG_OBJS:    if (live_slabs == 0) objs_reg = cfg_data[6:0];
                    soa_pkg::CFG_MAXFREE: keep_free = cfg_data[4:0];
                    soa_pkg::CFG_RELEN:   release_on = cfg_data[0];
                    default: ;
                endcase
            end
            // result beat against the oldest expectation
            if (m_valid && m_ready) begin
                if (owed_beats.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %p",
                             $realtime, m_data);
                    fail_count++;
                end else begin
                    want = owed_beats.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: result mismatch, expected %p, got %p",
                                 $realtime, want, m_data);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_allocator(s_data);
        end
        results_owed <= owed_beats.size();
    end

endmodule

[sim/slab_object_allocator_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator_unit_test
// Drives allocate, free and add-slab requests into the slab allocator with
// random gaps and result stalls, across several register settings, and
// leaves the checking to the checker beside the block.
// ----------------------------------------------------------------------------
module slab_object_allocator_unit_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 65;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    soa_pkg::in_beat_t  s_data;
    logic               m_valid;
    logic               m_ready;
    soa_pkg::out_beat_t m_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 results_owed;

    logic        quiet;
    int          stall_left;
    int          watchdog;
    logic [9:0]  granted_objs [$];

    slab_object_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slab_object_allocator_unit_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // result side stalls in bursts
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // keep track of granted objects so frees can be well formed
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.kind == soa_pkg::KIND_GRANT)
            granted_objs.push_back({m_data.out_slab, m_data.out_object});
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    function automatic soa_pkg::in_beat_t mk_req(logic [1:0] md, int slab, int obj,
                                                 logic [31:0] tag);
        soa_pkg::in_beat_t b;
        b.mode         = md;
        b.slab_index   = 4'(slab);
        b.object_index = 6'(obj);
        b.slab_tag     = tag;
        return b;
    endfunction

    // one request beat; valid stays high for a following request
    task automatic send_req(input soa_pkg::in_beat_t b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // lower valid and wait until every owed result has left
    task automatic settle();
        s_valid <= 1'b0;
        repeat (3) @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic free_granted();
        int idx;
        idx = $urandom_range(0, granted_objs.size() - 1);
        send_req(mk_req(soa_pkg::MODE_FREE, granted_objs[idx][9:6],
                        granted_objs[idx][5:0], $urandom));
        granted_objs.delete(idx);
    endtask

    task automatic random_req();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35 && granted_objs.size() > 0)
            free_granted();
        else if (pick < 75)
            send_req(mk_req(soa_pkg::MODE_ALLOC, $urandom, $urandom, $urandom));
        else if (pick < 90)
            send_req(mk_req(soa_pkg::MODE_ADD, $urandom_range(0, 15), $urandom, $urandom));
        else
            send_req(mk_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom));
    endtask

    // empty the pool so objs_per_slab can change
    task automatic drain_pool();
        settle();
        while (granted_objs.size() > 0) free_granted();
        settle();
        write_reg(soa_pkg::CFG_MAXFREE, 32'd0);
        write_reg(soa_pkg::CFG_RELEN, 32'd1);
        send_req(mk_req(soa_pkg::MODE_ALLOC, 0, 0, '0));
        settle();
        while (granted_objs.size() > 0) free_granted();
        settle();
    endtask

    initial begin
        logic [6:0] objs_set [PHASES];
        logic [4:0] keep_set [PHASES];
        logic       rel_set [PHASES];
        objs_set = '{7'd2, 7'd64, 7'd0, 7'd127, 7'($urandom_range(2, 20)),
                     7'($urandom_range(3, 12))};
        keep_set = '{5'd0, 5'd16, 5'd31, 5'd1, 5'($urandom_range(0, 16)),
                     5'($urandom_range(0, 3))};
        rel_set  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1};

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = soa_pkg::CFG_OBJS;
        cfg_data   = '0;
        quiet      = 1'b0;
        stall_left = 0;
        watchdog   = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: empty pool, bad requests, adds at the slot extremes, a full slab
        send_req(mk_req(soa_pkg::MODE_ALLOC, 0, 0, '0));
        send_req(mk_req(soa_pkg::MODE_FREE, 3, 0, '0));
        send_req(mk_req(2'd3, 15, 63, 32'hFFFF_FFFF));
        send_req(mk_req(soa_pkg::MODE_ADD, 0, 0, 32'h0000_0000));
        send_req(mk_req(soa_pkg::MODE_ADD, 15, 63, 32'hFFFF_FFFF));
        send_req(mk_req(soa_pkg::MODE_ADD, 0, 0, 32'h1234_5678));
        repeat (9) send_req(mk_req(soa_pkg::MODE_ALLOC, 0, 0, '0));
        send_req(mk_req(soa_pkg::MODE_FREE, 15, 63, '0));
        send_req(mk_req(soa_pkg::MODE_FREE, 15, 0, '0));
        send_req(mk_req(soa_pkg::MODE_FREE, 15, 0, '0));
        send_req(mk_req(soa_pkg::MODE_ADD, 7, 42, 32'hA5A5_5A5A));
        settle();
        granted_objs = granted_objs.find(g) with (g != {4'd15, 6'd0});

        // random phases over several register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pool();
            write_reg(soa_pkg::CFG_OBJS, 32'(objs_set[ph]));
            write_reg(soa_pkg::CFG_MAXFREE, 32'(keep_set[ph]));
            write_reg(soa_pkg::CFG_RELEN, 32'(rel_set[ph]));
            quiet = (ph == PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) random_req();
        end
        s_valid <= 1'b0;

        // wait out the last results
        repeat (3) @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
